### rtl/rv32em_r_type_execute_core_macros.svh
// assertion helpers for the execute core
`ifndef RV32EM_R_TYPE_EXECUTE_CORE_MACROS_SVH
`define RV32EM_R_TYPE_EXECUTE_CORE_MACROS_SVH
`define RX_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("%s failed", "label");
`define RX_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("%s failed", "label");
`endif

### rtl/rvx_pkg.sv
package rvx_pkg;
  typedef struct packed {
    logic [2:0] func;
    logic [6:0] group_code;
    logic [4:0] dest_index;
    logic [4:0] src1_index;
    logic [4:0] src2_index;
  } in_item_t;

  typedef struct packed {
    logic        illegal;
    logic        dest_written;
    logic [31:0] write_value;
    logic [31:0] pc_after;
  } out_item_t;

  typedef enum logic [2:0] {
    CLS_ALU = 3'b001,
    CLS_MUL = 3'b010,
    CLS_DIV = 3'b100
  } op_class_t;

  localparam logic [6:0] F7_BASE = 7'd0;
  localparam logic [6:0] F7_ALT  = 7'd32;
  localparam logic [6:0] F7_MULD = 7'd1;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_MUL    = 3'd0;
  localparam logic [2:0] F3_MULH   = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;
  localparam logic [2:0] F3_MULHU  = 3'd3;
  localparam logic [2:0] F3_DIV    = 3'd4;
  localparam logic [2:0] F3_DIVU   = 3'd5;
  localparam logic [2:0] F3_REM    = 3'd6;

  // classified instruction carried through the queue
  typedef struct packed {
    logic       illegal;
    op_class_t  cls;
    logic       alt;
    logic [2:0] func;
    logic [4:0] rd;
    logic [4:0] rs1;
    logic [4:0] rs2;
  } dec_item_t;
endpackage

### rtl/rvx_front.sv
module rvx_front #(
  parameter int REG_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rvx_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output rvx_pkg::dec_item_t q_data
);
  import rvx_pkg::*;

  localparam int DEPTH = 2;

  dec_item_t  slots [DEPTH];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  dec_item_t  dec;
  logic       range_bad, enc_bad;
  logic       push, pop;

  always_comb begin
    range_bad = (32'(in_data.dest_index) >= 32'(REG_COUNT)) ||
                (32'(in_data.src1_index) >= 32'(REG_COUNT)) ||
                (32'(in_data.src2_index) >= 32'(REG_COUNT));
    enc_bad = 1'b0;
    dec.cls = CLS_ALU;
    dec.alt = 1'b0;
    case (in_data.group_code)
      F7_BASE: dec.cls = CLS_ALU;
      F7_ALT: begin
        dec.alt = 1'b1;
        enc_bad = (in_data.func != F3_ADD) && (in_data.func != F3_SRL);
      end
      F7_MULD: dec.cls = in_data.func[2] ? CLS_DIV : CLS_MUL;
      default: enc_bad = 1'b1;
    endcase
    dec.illegal = range_bad || enc_bad;
    dec.func = in_data.func;
    dec.rd   = in_data.dest_index;
    dec.rs1  = in_data.src1_index;
    dec.rs2  = in_data.src2_index;
  end

  assign in_ready = (count != 2'(DEPTH));
  assign q_valid  = (count != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

### rtl/rvx_divider.sv
module rvx_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);
  logic [31:0] q, r, d;
  logic [5:0]  steps;
  logic [32:0] trial;

  assign trial = {r[31:0], q[31]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= 32'd0;
      d <= divisor;
    end else if (busy) begin
      // one restoring step per cycle
      if (!trial[32] || r[31]) begin
        r <= trial[31:0];
        q <= {q[30:0], 1'b1};
      end else begin
        r <= {r[30:0], q[31]};
        q <= {q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= 6'd0;
      done  <= 1'b0;
    end else begin
      done <= busy && (steps == 6'd1);
      if (start) steps <= 6'd32;
      else if (busy) steps <= steps - 6'd1;
    end
  end

  assign busy      = (steps != 6'd0);
  assign quotient  = q;
  assign remainder = r;
endmodule

### rtl/rvx_back.sv
module rvx_back #(
  parameter int REG_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  rvx_pkg::dec_item_t q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rvx_pkg::out_item_t out_data
);
  import rvx_pkg::*;
  `include "rv32em_r_type_execute_core_macros.svh"

  localparam int IW = $clog2(REG_COUNT);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [31:0] regs [REG_COUNT];
  logic [REG_COUNT-1:0] reg_valid;
  dec_item_t cur;
  logic [31:0] a, b, res, pc;
  logic [65:0] product;
  logic        div_start, div_busy, div_done;
  logic [31:0] div_q, div_r, div_a, div_b;
  logic        neg_a, neg_b, div_zero;
  logic [31:0] alu_res, div_res, final_res;
  logic        a_sgn, b_sgn;
  logic        wr;
  logic        out_illegal, out_written;

  assign q_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (q_valid && q_ready) state_next = S_READ;
      S_READ: begin
        if (cur.illegal) state_next = S_DONE;
        else if (cur.cls == CLS_MUL) state_next = S_MUL;
        else if (cur.cls == CLS_DIV) state_next = S_DIV;
        else state_next = S_DONE;
      end
      S_MUL: state_next = S_DONE;
      S_DIV: if (div_done) state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // operands read in the idle cycle, registered
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid && q_ready) begin
      cur <= q_data;
      a <= (q_data.rs1[IW-1:0] == '0 || !reg_valid[q_data.rs1[IW-1:0]]) ? 32'd0
           : regs[q_data.rs1[IW-1:0]];
      b <= (q_data.rs2[IW-1:0] == '0 || !reg_valid[q_data.rs2[IW-1:0]]) ? 32'd0
           : regs[q_data.rs2[IW-1:0]];
    end
  end

  always_comb begin
    case (cur.func)
      F3_ADD:  alu_res = cur.alt ? a - b : a + b;
      F3_SLL:  alu_res = a << b[4:0];
      F3_SLT:  alu_res = {31'd0, $signed(a) < $signed(b)};
      F3_SLTU: alu_res = {31'd0, a < b};
      F3_XOR:  alu_res = a ^ b;
      F3_SRL:  alu_res = cur.alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      F3_OR:   alu_res = a | b;
      default: alu_res = a & b;
    endcase
  end

  assign a_sgn = (cur.func == F3_MULH || cur.func == F3_MULHSU) && a[31];
  assign b_sgn = (cur.func == F3_MULH) && b[31];

  always_ff @(posedge clk) begin
    if (state == S_READ) product <= 66'($signed({a_sgn, a}) * $signed({b_sgn, b}));
  end

  assign neg_a    = !cur.func[0] && a[31];
  assign neg_b    = !cur.func[0] && b[31];
  assign div_zero = (b == 32'd0);
  assign div_a    = neg_a ? 32'd0 - a : a;
  assign div_b    = neg_b ? 32'd0 - b : b;
  assign div_start = (state == S_READ) && !cur.illegal && (cur.cls == CLS_DIV);

  rvx_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  always_comb begin
    if (cur.func[1]) begin
      if (div_zero) div_res = a;
      else div_res = neg_a ? 32'd0 - div_r : div_r;
    end else begin
      if (div_zero) div_res = 32'hFFFF_FFFF;
      else div_res = (neg_a != neg_b) ? 32'd0 - div_q : div_q;
    end
  end

  always_comb begin
    case (cur.cls)
      CLS_MUL: final_res = (cur.func == F3_MUL) ? product[31:0] : product[63:32];
      CLS_DIV: final_res = div_res;
      default: final_res = alu_res;
    endcase
  end

  assign wr = !cur.illegal && (cur.rd != 5'd0);

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && wr) regs[cur.rd[IW-1:0]] <= final_res;
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) res <= wr ? final_res : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      reg_valid   <= '0;
      pc          <= 32'd0;
      out_valid   <= 1'b0;
      out_illegal <= 1'b0;
      out_written <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == S_DONE) begin
        if (wr) reg_valid[cur.rd[IW-1:0]] <= 1'b1;
        if (!cur.illegal) pc <= pc + 32'd4;
        out_valid   <= 1'b1;
        out_illegal <= cur.illegal;
        out_written <= wr;
      end
    end
  end

  assign out_data = '{illegal: out_illegal, dest_written: out_written,
                      write_value: res, pc_after: pc};

  `RX_ASSERT_IMP(a_no_accept_busy, clk, rst, state != S_IDLE, !q_ready)
  `RX_ASSERT_NXT(a_done_valid, clk, rst, state == S_DONE, out_valid)
  `RX_ASSERT_IMP(a_div_only_in_div, clk, rst, div_busy, state == S_DIV)
endmodule

### rtl/rv32em_r_type_execute_core.sv
// back-end path: alu ops and illegal items pass idle, read, done; multiply adds mul; divide waits in div
// throughput: one item at a time in the back end; a divide holds it for the 32-step radix-2 divider
// the 2-entry queue lets the front take items while the back is busy
// reset: synchronous active-high rst clears the queue, pc and register valid bits
module rv32em_r_type_execute_core #(
  parameter int REG_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rvx_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rvx_pkg::out_item_t out_data
);
  import rvx_pkg::*;

  logic      q_valid, q_ready;
  dec_item_t q_data;

  rvx_front #(.REG_COUNT(REG_COUNT)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  rvx_back #(.REG_COUNT(REG_COUNT)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule

### bench/rv32em_r_type_execute_checker.sv
`timescale 1ns / 100ps
module rv32em_r_type_execute_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  rvx_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  rvx_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending_count
);
  import rvx_pkg::*;

  logic [31:0] regs [16];
  logic [31:0] pc_model;
  out_item_t   exp_results [$];

  function automatic logic [31:0] signed_div(logic [31:0] a, logic [31:0] b, bit want_rem);
    logic [31:0] ma, mb, q, r;
    if (b == 32'd0) return want_rem ? a : 32'hffffffff;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    r = ma % mb;
    if (a[31] != b[31]) q = -q;
    if (a[31]) r = -r;
    return want_rem ? r : q;
  endfunction

  // returns 0 when the encoding is unknown
  function automatic bit alu_result(logic [2:0] f3, logic [6:0] f7, logic [31:0] a,
                                    logic [31:0] b, output logic [31:0] res);
    logic [4:0]  sh;
    logic [63:0] p;
    sh = b[4:0];
    res = 32'd0;
    if (f7 == F7_BASE) begin
      case (f3)
        F3_ADD:  res = a + b;
        F3_SLL:  res = a << sh;
        F3_SLT:  res = {31'd0, $signed(a) < $signed(b)};
        F3_SLTU: res = {31'd0, a < b};
        F3_XOR:  res = a ^ b;
        F3_SRL:  res = a >> sh;
        F3_OR:   res = a | b;
        default: res = a & b;
      endcase
      return 1;
    end
    if (f7 == F7_ALT) begin
      if (f3 == F3_ADD) begin
        res = a - b;
        return 1;
      end
      if (f3 == F3_SRL) begin
        res = $signed(a) >>> sh;
        return 1;
      end
      return 0;
    end
    if (f7 == F7_MULD) begin
      case (f3)
        F3_MUL:    res = a * b;
        F3_MULH: begin
          p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
          res = p[63:32];
        end
        F3_MULHSU: begin
          p = {{32{a[31]}}, a} * {32'd0, b};
          res = p[63:32];
        end
        F3_MULHU: begin
          p = {32'd0, a} * {32'd0, b};
          res = p[63:32];
        end
        F3_DIV:  res = signed_div(a, b, 0);
        F3_DIVU: res = (b == 0) ? 32'hffffffff : a / b;
        F3_REM:  res = signed_div(a, b, 1);
        default: res = (b == 0) ? a : a % b;
      endcase
      return 1;
    end
    return 0;
  endfunction

  task automatic execute_instr(in_item_t ins);
    out_item_t   o;
    logic [31:0] a, b, res;
    bit          ok;
    ok = 0;
    res = 32'd0;
    o = '0;
    if (ins.dest_index < 16 && ins.src1_index < 16 && ins.src2_index < 16) begin
      a = regs[ins.src1_index[3:0]];
      b = regs[ins.src2_index[3:0]];
      ok = alu_result(ins.func, ins.group_code, a, b, res);
    end
    if (ok) begin
      if (ins.dest_index != 0) begin
        regs[ins.dest_index[3:0]] = res;
        o.dest_written = 1'b1;
        o.write_value = res;
      end
      pc_model = pc_model + 32'd4;
    end
    o.illegal = !ok;
    o.pc_after = pc_model;
    exp_results.push_back(o);
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      foreach (regs[i]) regs[i] = 32'd0;
      pc_model = 32'd0;
      exp_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (exp_results.size() == 0) begin
          $error("result item with nothing expected");
          fail_count++;
        end else begin
          e = exp_results.pop_front();
          if (e.illegal !== out_data.illegal) begin
            $error("illegal: expected %0d, got %0d", e.illegal, out_data.illegal);
            fail_count++;
          end
          if (e.dest_written !== out_data.dest_written) begin
            $error("dest_written: expected %0d, got %0d", e.dest_written,
                   out_data.dest_written);
            fail_count++;
          end
          if (e.write_value !== out_data.write_value) begin
            $error("write_value: expected %h, got %h", e.write_value, out_data.write_value);
            fail_count++;
          end
          if (e.pc_after !== out_data.pc_after) begin
            $error("pc_after: expected %h, got %h", e.pc_after, out_data.pc_after);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) execute_instr(in_data);
    end
    pending_count = exp_results.size();
  end

  initial begin
    fail_count = 0;
    pending_count = 0;
  end
endmodule

### bench/rv32em_r_type_execute_core_tb.sv
`timescale 1ns / 100ps
module rv32em_r_type_execute_core_tb;
  import rvx_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count, pending_count;
  bit        calm_phase = 0;
  bit        hold_sink = 0;

  rv32em_r_type_execute_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  rv32em_r_type_execute_checker checker_i (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic in_item_t make_instr(logic [2:0] f3, logic [6:0] f7, logic [4:0] rd,
                                          logic [4:0] rs1, logic [4:0] rs2);
    in_item_t t;
    t.func = f3;
    t.group_code = f7;
    t.dest_index = rd;
    t.src1_index = rs1;
    t.src2_index = rs2;
    return t;
  endfunction

  task automatic send_instr(in_item_t t);
    int gap;
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic in_item_t random_instr();
    logic [6:0] f7;
    logic [4:0] rd, rs1, rs2;
    case ($urandom_range(0, 9))
      0, 1, 2: f7 = F7_BASE;
      3, 4:    f7 = F7_ALT;
      5, 6, 7, 8: f7 = F7_MULD;
      default: f7 = 7'($urandom);
    endcase
    if ($urandom_range(0, 11) == 0) begin
      rd = 5'($urandom);
      rs1 = 5'($urandom);
      rs2 = 5'($urandom);
    end else begin
      rd = 5'($urandom_range(0, 15));
      rs1 = 5'($urandom_range(0, 15));
      rs2 = 5'($urandom_range(0, 15));
    end
    return make_instr(3'($urandom), f7, rd, rs1, rs2);
  endfunction

  // clear rd, then load it with the sum of two random registers
  task automatic seed_reg(logic [4:0] rd);
    send_instr(make_instr(F3_ADD, F7_ALT, rd, rd, rd));
    send_instr(make_instr(F3_ADD, F7_BASE, rd, 5'($urandom_range(0, 15)),
                          5'($urandom_range(0, 15))));
  endtask

  // receiver: random stalls, one long hold-off, none at the end
  always @(negedge clk) begin
    if (rst || hold_sink) out_ready <= 1'b0;
    else if (calm_phase) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // start from zeros: sltu of x0 with x0 gives 0, then sub of x1 from x0 gives 0
    send_instr(make_instr(F3_SLTU, F7_BASE, 5'd1, 5'd0, 5'd0));
    send_instr(make_instr(F3_ADD, F7_ALT, 5'd2, 5'd0, 5'd1));
    send_instr(make_instr(F3_SRL, F7_BASE, 5'd3, 5'd2, 5'd0));
    send_instr(make_instr(F3_SLL, F7_BASE, 5'd4, 5'd2, 5'd2));   // 0x00000000
    send_instr(make_instr(F3_SLL, F7_BASE, 5'd5, 5'd2, 5'd2));
    send_instr(make_instr(F3_SLT, F7_BASE, 5'd6, 5'd2, 5'd0));   // 0 < 0
    send_instr(make_instr(F3_SLTU, F7_BASE, 5'd7, 5'd0, 5'd2));
    send_instr(make_instr(F3_DIV, F7_MULD, 5'd8, 5'd4, 5'd2));   // divide by zero
    send_instr(make_instr(F3_REM, F7_MULD, 5'd9, 5'd4, 5'd2));
    send_instr(make_instr(F3_DIV, F7_MULD, 5'd10, 5'd4, 5'd0));  // divide by zero
    send_instr(make_instr(F3_DIVU, F7_MULD, 5'd11, 5'd4, 5'd0));
    send_instr(make_instr(F3_REM, F7_MULD, 5'd12, 5'd2, 5'd0));
    send_instr(make_instr(3'd7, F7_MULD, 5'd13, 5'd4, 5'd0));
    send_instr(make_instr(F3_MULH, F7_MULD, 5'd14, 5'd4, 5'd4));
    send_instr(make_instr(F3_MULHSU, F7_MULD, 5'd15, 5'd2, 5'd2));
    send_instr(make_instr(F3_MULHU, F7_MULD, 5'd13, 5'd2, 5'd2));
    send_instr(make_instr(F3_MUL, F7_MULD, 5'd12, 5'd2, 5'd2));
    send_instr(make_instr(F3_SRL, F7_ALT, 5'd11, 5'd4, 5'd3));   // arithmetic shift
    send_instr(make_instr(F3_XOR, F7_BASE, 5'd0, 5'd2, 5'd3));   // destination zero
    send_instr(make_instr(F3_OR, F7_BASE, 5'd31, 5'd2, 5'd3));   // index out of range
    send_instr(make_instr(F3_AND, F7_BASE, 5'd1, 5'd16, 5'd31));
    send_instr(make_instr(F3_XOR, F7_ALT, 5'd1, 5'd2, 5'd3));    // unknown alt encoding
    send_instr(make_instr(F3_ADD, 7'd127, 5'd1, 5'd2, 5'd3));
    send_instr(make_instr(F3_REM, F7_MULD, 5'd9, 5'd6, 5'd2));   // rem by zero
    // long receiver hold-off while items keep coming
    hold_sink = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_sink = 1'b0;
      end
      repeat (12) send_instr(random_instr());
    join
    for (int i = 0; i < 1700; i++) begin
      if (i == 1450) calm_phase = 1'b1;
      if ($urandom_range(0, 15) == 0) seed_reg(5'($urandom_range(1, 15)));
      else send_instr(random_instr());
    end
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
